// ----- design/text_console_control_interpreter_core_assert.svh -----
// ----------------------------------------------------------------------------
// Text console assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CONTROL_INTERPRETER_CORE_ASSERT_SVH
`define TEXT_CONSOLE_CONTROL_INTERPRETER_CORE_ASSERT_SVH

// consequent holds in the same cycle as the antecedent
`define TCCI_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcci same-cycle check failed");

// consequent holds in the cycle after the antecedent
`define TCCI_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcci next-cycle check failed");

`endif

// ----- design/tcci_pkg.sv -----
// ----------------------------------------------------------------------------
// Text console package
// Sizes, cell format, console codes, sequencer states and helpers.
// ----------------------------------------------------------------------------
package tcci_pkg;

  localparam int MaxColumns = 64;
  localparam int MaxRows    = 32;
  localparam int ColW       = $clog2(MaxColumns);
  localparam int RowW       = $clog2(MaxRows);
  localparam int NcolW      = ColW + 1;
  localparam int NrowW      = RowW + 1;
  localparam int AddrW      = ColW + RowW;
  localparam int CellDepth  = MaxColumns * MaxRows;

  typedef logic [ColW-1:0]  col_t;
  typedef logic [RowW-1:0]  row_t;
  typedef logic [NcolW-1:0] ncol_t;
  typedef logic [NrowW-1:0] nrow_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [15:0]      cell_t;

  localparam cell_t    BlankCell    = 16'h0720;
  localparam logic [7:0] SpaceChar  = 8'h20;
  localparam logic [6:0] ColumnsReset = 7'd53;
  localparam logic [5:0] RowsReset    = 6'd30;
  localparam logic [3:0] InkReset     = 4'd7;

  localparam logic [3:0] CfgColumns = 4'd0;
  localparam logic [3:0] CfgRows    = 4'd1;

  localparam logic [7:0] CodeLeft      = 8'd1;
  localparam logic [7:0] CodeRight     = 8'd4;
  localparam logic [7:0] CodeInsert    = 8'd5;
  localparam logic [7:0] CodeBackspace = 8'd8;
  localparam logic [7:0] CodeTab       = 8'd9;
  localparam logic [7:0] CodeLineFeed  = 8'd10;
  localparam logic [7:0] CodeClear     = 8'd12;
  localparam logic [7:0] CodeEnter     = 8'd13;
  localparam logic [7:0] CodeDown      = 8'd19;
  localparam logic [7:0] CodeHome      = 8'd20;
  localparam logic [7:0] CodeVtab      = 8'd22;
  localparam logic [7:0] CodeUp        = 8'd23;
  localparam logic [7:0] CodeReverse   = 8'd24;
  localparam logic [7:0] CodeDelete    = 8'd26;
  localparam logic [7:0] CodePrintLow  = 8'h20;
  localparam logic [7:0] CodeRubout    = 8'd127;
  localparam logic [7:0] CodeInkBase   = 8'h80;
  localparam logic [7:0] CodePaperBase = 8'h90;
  localparam logic [7:0] CodePrintHigh = 8'hA0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_SEEK,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_INS_RD,
    ST_INS_WR,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_FILL,
    ST_FINISH
  } state_e;

  function automatic ncol_t sat_cols(logic [6:0] v);
    if (v == '0) return ncol_t'(1);
    else if (int'(v) > MaxColumns) return ncol_t'(MaxColumns);
    else return ncol_t'(v);
  endfunction

  function automatic nrow_t sat_rows(logic [5:0] v);
    if (v == '0) return nrow_t'(1);
    else if (int'(v) > MaxRows) return nrow_t'(MaxRows);
    else return nrow_t'(v);
  endfunction

  function automatic addr_t cell_addr(col_t x, row_t y);
    return {y, x};
  endfunction

endpackage

// ----- design/text_console_control_interpreter_core.sv -----
// ----------------------------------------------------------------------------
// Text console control interpreter core
// Character-cell console: interprets code bytes and serves cell reads.
// ----------------------------------------------------------------------------
// One word in, one word out. A read, a cursor or colour code, or a printed
// character that does not scroll goes from idle to the finish state, which
// loads its result into the output register and frees the input; the
// finish state waits while the output is full and stalled. Moves that
// shift the cell store go through one shared address walker and the single
// port pair of the cell RAM; each moved cell is read in a read state and
// then written in a write state. Delete and insert first search the rows
// of the wrapped line for its end; a scroll moves the rows up and then
// blanks the bottom row; clear writes every cell blank. After reset the RAM
// is swept to blank before the first word is taken; configuration writes
// are likewise taken only once the core is idle. The
// input is stalled while a word is in work; a finished result sits in an
// output register so the next word may enter while it waits.
// ----------------------------------------------------------------------------
module text_console_control_interpreter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [7:0]         code_i,
  input  tcci_pkg::col_t     read_col_i,
  input  tcci_pkg::row_t     read_row_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         cell_char_o,
  output logic [3:0]         cell_ink_o,
  output logic [3:0]         cell_paper_o,
  output tcci_pkg::col_t     cursor_col_o,
  output tcci_pkg::row_t     cursor_row_o,
  output logic [3:0]         ink_now_o,
  output logic [3:0]         paper_now_o,
  output logic               reverse_request_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [6:0]         cfg_data_i
);
  import tcci_pkg::*;

  // cell RAM
  cell_t mem [CellDepth];
  cell_t rdata_q;
  logic  mem_we, mem_re;
  addr_t mem_waddr, mem_raddr;
  cell_t mem_wdata;

  state_e state_q, state_d;
  logic [6:0] columns_q, columns_d;
  logic [5:0] rows_q, rows_d;
  col_t col_q, col_d, x_q, x_d;
  row_t row_q, row_d, y_q, y_d, last_q, last_d;
  logic [3:0] ink_q, ink_d, paper_q, paper_d;
  logic [MaxRows-1:0] ext_q, ext_d;
  addr_t clr_q, clr_d;
  logic ins_q, ins_d;            // walk kind after line-end search
  logic item_q, item_d;          // a word is in work
  logic rd_q, rd_d, hit_q, hit_d, rev_q, rev_d;

  logic out_valid_q, out_valid_d;
  logic [7:0] o_char_q, o_char_d;
  logic [3:0] o_ink_q, o_ink_d, o_pap_q, o_pap_d, o_inkn_q, o_inkn_d, o_papn_q, o_papn_d;
  col_t o_col_q, o_col_d;
  row_t o_row_q, o_row_d;
  logic o_rev_q, o_rev_d;

  ncol_t ncols;
  nrow_t nrows;
  col_t  col_last;
  row_t  row_last;
  logic  in_acc, cfg_acc;
  logic  is_print, is_ink, is_paper, can_bs, bot_row, col_end;
  logic  seek_more, scr_done, del_end, ins_end, x_end;
  col_t  nx, px;
  row_t  ny, py;
  ncol_t tab_n;
  nrow_t vtab_n;
  cell_t space_cell;
  logic  out_load;

  assign ncols    = sat_cols(columns_q);
  assign nrows    = sat_rows(rows_q);
  assign col_last = col_t'(ncols - 1'b1);
  assign row_last = row_t'(nrows - 1'b1);

  assign in_stall_o  = (state_q != ST_IDLE) || cfg_valid_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign cfg_acc     = cfg_valid_i && cfg_ready_o;

  // code classes
  assign is_print = ((code_i >= CodePrintLow) && (code_i < CodeRubout))
                    || (code_i >= CodePrintHigh);
  assign is_ink   = (code_i >= CodeInkBase) && (code_i < CodePaperBase);
  assign is_paper = (code_i >= CodePaperBase) && (code_i < CodePrintHigh);
  assign can_bs   = (col_q != '0) || ((row_q != '0) && ext_q[row_q - 1'b1]);
  assign bot_row  = (row_q == row_last);
  assign col_end  = (col_q == col_last);
  assign tab_n    = ({1'b0, col_q} | ncol_t'(7)) + 1'b1;
  assign vtab_n   = ({1'b0, row_q} | nrow_t'(7)) + 1'b1;
  assign space_cell = {paper_q, ink_q, SpaceChar};

  // shared walker stepping
  assign x_end     = (x_q == col_last);
  assign nx        = x_end ? '0 : x_q + 1'b1;
  assign ny        = x_end ? y_q + 1'b1 : y_q;
  assign px        = (x_q == '0) ? col_last : x_q - 1'b1;
  assign py        = (x_q == '0) ? y_q - 1'b1 : y_q;
  assign seek_more = ((nrow_t'(y_q) + 1'b1) < nrows) && ext_q[y_q];
  assign scr_done  = (nrow_t'(y_q) + 1'b1) >= nrows;
  assign del_end   = x_end && (y_q == last_q);
  assign ins_end   = (x_q == col_q) && (y_q == row_q);
  assign out_load  = (state_q == ST_FINISH) && item_q && (!out_valid_q || !out_stall_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (cmd_i) begin
            state_d = ST_FINISH;
          end else begin
            case (code_i)
              CodeInsert, CodeDelete: state_d = ST_SEEK;
              CodeBackspace: state_d = can_bs ? ST_SEEK : ST_FINISH;
              CodeLineFeed, CodeEnter: state_d = bot_row ? ST_SCR_RD : ST_FINISH;
              CodeClear: state_d = ST_CLEAR;
              default: begin
                if (is_print && col_end && bot_row) state_d = ST_SCR_RD;
                else state_d = ST_FINISH;
              end
            endcase
          end
        end
      end
      ST_CLEAR:  if (clr_q == addr_t'(CellDepth - 1)) state_d = ST_FINISH;
      ST_SEEK:   if (!seek_more) state_d = ins_q ? ST_INS_RD : ST_DEL_RD;
      ST_DEL_RD: state_d = del_end ? ST_FINISH : ST_DEL_WR;
      ST_DEL_WR: state_d = ST_DEL_RD;
      ST_INS_RD: state_d = ins_end ? ST_FINISH : ST_INS_WR;
      ST_INS_WR: state_d = ST_INS_RD;
      ST_SCR_RD: state_d = scr_done ? ST_FILL : ST_SCR_WR;
      ST_SCR_WR: state_d = ST_SCR_RD;
      ST_FILL:   if (x_end) state_d = ST_FINISH;
      ST_FINISH: if (!item_q || out_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and RAM control
  always_comb begin
    columns_d = columns_q;
    rows_d    = rows_q;
    col_d     = col_q;
    row_d     = row_q;
    ink_d     = ink_q;
    paper_d   = paper_q;
    ext_d     = ext_q;
    x_d       = x_q;
    y_d       = y_q;
    last_d    = last_q;
    clr_d     = clr_q;
    ins_d     = ins_q;
    item_d    = item_q;
    rd_d      = rd_q;
    hit_d     = hit_q;
    rev_d     = rev_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cell_addr(x_q, y_q);
    mem_raddr = cell_addr(nx, ny);
    mem_wdata = rdata_q;

    out_valid_d = out_valid_q;
    o_char_d = o_char_q;
    o_ink_d  = o_ink_q;
    o_pap_d  = o_pap_q;
    o_col_d  = o_col_q;
    o_row_d  = o_row_q;
    o_inkn_d = o_inkn_q;
    o_papn_d = o_papn_q;
    o_rev_d  = o_rev_q;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cfg_acc) begin
          if (cfg_index_i == CfgColumns) begin
            columns_d = cfg_data_i;
            if (ncol_t'(col_q) >= sat_cols(cfg_data_i)) begin
              col_d = col_t'(sat_cols(cfg_data_i) - 1'b1);
            end
          end else if (cfg_index_i == CfgRows) begin
            rows_d = cfg_data_i[5:0];
            if (nrow_t'(row_q) >= sat_rows(cfg_data_i[5:0])) begin
              row_d = row_t'(sat_rows(cfg_data_i[5:0]) - 1'b1);
            end
          end
        end
        if (in_acc) begin
          item_d = 1'b1;
          rd_d   = cmd_i;
          hit_d  = 1'b0;
          rev_d  = 1'b0;
          x_d    = '0;
          y_d    = '0;
          if (cmd_i) begin
            hit_d     = (ncol_t'(read_col_i) < ncols) && (nrow_t'(read_row_i) < nrows);
            mem_re    = 1'b1;
            mem_raddr = cell_addr(read_col_i, read_row_i);
          end else begin
            case (code_i)
              CodeLeft:  col_d = (col_q == '0) ? col_last : col_q - 1'b1;
              CodeRight: col_d = col_end ? '0 : col_q + 1'b1;
              CodeInsert: begin
                ins_d = 1'b1;
                y_d   = row_q;
              end
              CodeDelete: begin
                ins_d = 1'b0;
                y_d   = row_q;
              end
              CodeBackspace: begin
                ins_d = 1'b0;
                if (col_q == '0) begin
                  if (can_bs) begin
                    col_d = col_last;
                    row_d = row_q - 1'b1;
                    y_d   = row_q - 1'b1;
                  end
                end else begin
                  col_d = col_q - 1'b1;
                  y_d   = row_q;
                end
              end
              CodeTab: begin
                if (tab_n >= ncols) begin
                  col_d = '0;
                  row_d = bot_row ? '0 : row_q + 1'b1;
                end else begin
                  col_d = col_t'(tab_n);
                end
              end
              CodeLineFeed: if (!bot_row) row_d = row_q + 1'b1;
              CodeEnter: begin
                ext_d[row_q] = 1'b0;
                col_d = '0;
                if (!bot_row) row_d = row_q + 1'b1;
              end
              CodeClear: begin
                col_d = '0;
                row_d = '0;
                ext_d = '0;
                clr_d = '0;
              end
              CodeDown: row_d = bot_row ? '0 : row_q + 1'b1;
              CodeHome: begin
                col_d = '0;
                row_d = '0;
              end
              CodeVtab: row_d = (vtab_n >= nrows) ? '0 : row_t'(vtab_n);
              CodeUp:   row_d = (row_q == '0) ? row_last : row_q - 1'b1;
              CodeReverse: rev_d = 1'b1;
              default: begin
                if (is_print) begin
                  mem_we    = 1'b1;
                  mem_waddr = cell_addr(col_q, row_q);
                  mem_wdata = {paper_q, ink_q, code_i};
                  if (col_end) begin
                    ext_d[row_q] = 1'b1;
                    col_d = '0;
                    if (!bot_row) row_d = row_q + 1'b1;
                  end else begin
                    col_d = col_q + 1'b1;
                  end
                end else if (is_ink) begin
                  ink_d = code_i[3:0];
                end else if (is_paper) begin
                  paper_d = code_i[3:0];
                end
              end
            endcase
          end
        end
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = BlankCell;
        clr_d     = clr_q + 1'b1;
      end
      ST_SEEK: begin
        if (seek_more) begin
          y_d = y_q + 1'b1;
        end else begin
          last_d = y_q;
          if (ins_q) begin
            x_d = col_last;
          end else begin
            x_d = col_q;
            y_d = row_q;
          end
        end
      end
      ST_DEL_RD: begin
        if (del_end) begin
          mem_we    = 1'b1;
          mem_wdata = space_cell;
        end else begin
          mem_re = 1'b1;
        end
      end
      ST_DEL_WR: begin
        mem_we = 1'b1;
        x_d    = nx;
        y_d    = ny;
      end
      ST_INS_RD: begin
        if (ins_end) begin
          mem_we    = 1'b1;
          mem_wdata = space_cell;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cell_addr(px, py);
        end
      end
      ST_INS_WR: begin
        mem_we = 1'b1;
        x_d    = px;
        y_d    = py;
      end
      ST_SCR_RD: begin
        if (scr_done) begin
          x_d = '0;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = cell_addr(x_q, y_q + 1'b1);
        end
      end
      ST_SCR_WR: begin
        mem_we = 1'b1;
        x_d    = nx;
        y_d    = ny;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = space_cell;
        x_d       = nx;
        if (x_end) begin
          // flags follow their rows up; the new bottom row is plain
          for (int i = 0; i < MaxRows; i++) begin
            if ((i < MaxRows - 1) && ((nrow_t'(i) + 1'b1) < nrows)) begin
              ext_d[i] = ext_q[(i + 1) % MaxRows];
            end else if (row_t'(i) == row_last) begin
              ext_d[i] = 1'b0;
            end
          end
        end
      end
      ST_FINISH: begin
        if (out_load) begin
          item_d      = 1'b0;
          out_valid_d = 1'b1;
          o_char_d    = (rd_q && hit_q) ? rdata_q[7:0]   : '0;
          o_ink_d     = (rd_q && hit_q) ? rdata_q[11:8]  : '0;
          o_pap_d     = (rd_q && hit_q) ? rdata_q[15:12] : '0;
          o_col_d     = col_q;
          o_row_d     = row_q;
          o_inkn_d    = ink_q;
          o_papn_d    = paper_q;
          o_rev_d     = rev_q;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;   // blank sweep of the RAM after reset
      columns_q   <= ColumnsReset;
      rows_q      <= RowsReset;
      col_q       <= '0;
      row_q       <= '0;
      ink_q       <= InkReset;
      paper_q     <= '0;
      ext_q       <= '0;
      x_q         <= '0;
      y_q         <= '0;
      last_q      <= '0;
      clr_q       <= '0;
      ins_q       <= 1'b0;
      item_q      <= 1'b0;
      rd_q        <= 1'b0;
      hit_q       <= 1'b0;
      rev_q       <= 1'b0;
      out_valid_q <= 1'b0;
      o_char_q    <= '0;
      o_ink_q     <= '0;
      o_pap_q     <= '0;
      o_col_q     <= '0;
      o_row_q     <= '0;
      o_inkn_q    <= '0;
      o_papn_q    <= '0;
      o_rev_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      columns_q   <= columns_d;
      rows_q      <= rows_d;
      col_q       <= col_d;
      row_q       <= row_d;
      ink_q       <= ink_d;
      paper_q     <= paper_d;
      ext_q       <= ext_d;
      x_q         <= x_d;
      y_q         <= y_d;
      last_q      <= last_d;
      clr_q       <= clr_d;
      ins_q       <= ins_d;
      item_q      <= item_d;
      rd_q        <= rd_d;
      hit_q       <= hit_d;
      rev_q       <= rev_d;
      out_valid_q <= out_valid_d;
      o_char_q    <= o_char_d;
      o_ink_q     <= o_ink_d;
      o_pap_q     <= o_pap_d;
      o_col_q     <= o_col_d;
      o_row_q     <= o_row_d;
      o_inkn_q    <= o_inkn_d;
      o_papn_q    <= o_papn_d;
      o_rev_q     <= o_rev_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign cell_char_o       = o_char_q;
  assign cell_ink_o        = o_ink_q;
  assign cell_paper_o      = o_pap_q;
  assign cursor_col_o      = o_col_q;
  assign cursor_row_o      = o_row_q;
  assign ink_now_o         = o_inkn_q;
  assign paper_now_o       = o_papn_q;
  assign reverse_request_o = o_rev_q;

endmodule

// ----- design/tcci_checker.sv -----
// ----------------------------------------------------------------------------
// Text console port checker
// Watches the top-level ports over time; bound to the core.
// ----------------------------------------------------------------------------
`include "text_console_control_interpreter_core_assert.svh"

module tcci_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [7:0]         cell_char_o,
  input logic [3:0]         cell_ink_o,
  input logic [3:0]         cell_paper_o,
  input tcci_pkg::col_t     cursor_col_o,
  input logic               reverse_request_o,
  input logic               cfg_valid_i,
  input logic               cfg_ready_o
);

  `TCCI_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o)
  `TCCI_ASSERT_NEXT(a_out_stable, out_valid_o && out_stall_i, $stable(cursor_col_o))
  // one word in work at a time
  `TCCI_ASSERT_NEXT(a_busy_after_take, in_valid_i && !in_stall_o, in_stall_o)
  // reverse only comes from a write, which carries no cell
  `TCCI_ASSERT_SAME(a_rev_no_cell, out_valid_o && reverse_request_o,
                    cell_char_o == '0 && cell_ink_o == '0 && cell_paper_o == '0)
  // a register write never races a word
  `TCCI_ASSERT_SAME(a_cfg_blocks_in, cfg_valid_i && cfg_ready_o, in_stall_o)

endmodule

bind text_console_control_interpreter_core tcci_checker u_tcci_checker (.*);
